>>> design/sqe_pkg.sv
package sqe_pkg;

  localparam int unsigned DepthDef = 32;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ValueW  = 32;

  localparam logic [CmdW-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PRINT = 3'd1;
  localparam logic [CmdW-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP   = 3'd3;
  localparam logic [CmdW-1:0] CMD_SWAP  = 3'd4;

  localparam logic [StatusW-1:0] STAT_OK         = 3'd0;
  localparam logic [StatusW-1:0] STAT_PEEK_EMPTY = 3'd1;
  localparam logic [StatusW-1:0] STAT_POP_EMPTY  = 3'd2;
  localparam logic [StatusW-1:0] STAT_SWAP_SHORT = 3'd3;
  localparam logic [StatusW-1:0] STAT_PUSH_FULL  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PEEK,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SWAP_DONE,
    ST_PR_READ,
    ST_PR_OUT
  } sqe_state_e;

  typedef enum logic [1:0] {
    RSEL_TOP,
    RSEL_NEXT,
    RSEL_PTR
  } sqe_rsel_e;

  typedef struct packed {
    logic                latch;
    logic                push;
    logic                pop;
    logic                rd_en;
    sqe_rsel_e           rd_sel;
    logic                tmp_load;
    logic                swap_wr_top;
    logic                swap_wr_next;
    logic                ptr_init;
    logic                ptr_step;
    logic                emit;
    logic                emit_data;
    logic [StatusW-1:0]  emit_status;
    logic                emit_last;
  } sqe_cmd_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            empty;
    logic            full;
    logic            short;
    logic            out_free;
    logic            print_last;
  } sqe_stat_t;

endpackage

>>> design/stack_queue_engine.sv
// Bounded store of DEPTH signed 32-bit entries kept in a ring buffer, used as
// a stack (queue_mode 0, push on top) or a queue (queue_mode 1, push after the
// bottom). Requests arrive on s_axis with the command in tuser and the push
// value in tdata; results leave on m_axis, one per push, pop, peek or swap and
// one per entry for print-all (none when empty), tlast marking the final one.
// One request is handled at a time by a state machine over a single-port
// entry memory with registered read: push, pop, ignored codes and error
// results finish in the execute state, peek adds a result state, swap adds
// hold, write and done states, and print-all a read and an output state per
// entry. Every result also waits while the output register is still held
// by the sink. A finished result waits in the output register while the
// next request is taken. Write cfg_we_i/cfg_wdata_i only when idle.
module stack_queue_engine import sqe_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,     // queue_mode
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ValueW-1:0] s_axis_tdata_i,  // [31:0] push_value
  input  logic [CmdW-1:0]   s_axis_tuser_i,  // [2:0] cmd
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [ValueW-1:0] m_axis_tdata_o,  // [31:0] data_value
  output logic [StatusW:0]  m_axis_tuser_o,  // [0] has_data, [3:1] status
  output logic              m_axis_tlast_o
);

  sqe_cmd_t  dp_cmd;
  sqe_stat_t dp_stat;

  logic signed [ValueW-1:0] out_data;
  logic                     out_has_data;
  logic [StatusW-1:0]       out_status;

  sqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  sqe_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_cmd_i       (s_axis_tuser_i),
    .in_value_i     (s_axis_tdata_i),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_data_o     (out_data),
    .out_has_data_o (out_has_data),
    .out_status_o   (out_status),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_data;
  assign m_axis_tuser_o = {out_status, out_has_data};

endmodule

>>> design/sqe_ctrl.sv
module sqe_ctrl import sqe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sqe_stat_t stat_i,
  output sqe_cmd_t  cmd_o
);

  sqe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat_i.cmd)
          CMD_PUSH, CMD_POP: begin
            if (stat_i.out_free) state_d = ST_IDLE;
          end
          CMD_PEEK: begin
            if (!stat_i.empty) state_d = ST_PEEK;
            else if (stat_i.out_free) state_d = ST_IDLE;
          end
          CMD_SWAP: begin
            if (!stat_i.short) state_d = ST_SWAP_A;
            else if (stat_i.out_free) state_d = ST_IDLE;
          end
          CMD_PRINT: begin
            state_d = stat_i.empty ? ST_IDLE : ST_PR_READ;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_PEEK: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_SWAP_A:  state_d = ST_SWAP_B;
      ST_SWAP_B:  state_d = ST_SWAP_DONE;
      ST_SWAP_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_PR_READ: state_d = ST_PR_OUT;
      ST_PR_OUT: begin
        if (stat_i.out_free) state_d = stat_i.print_last ? ST_IDLE : ST_PR_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.rd_sel      = RSEL_TOP;
    cmd_o.emit_status = STAT_OK;
    in_ready_o        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EXEC: begin
        case (stat_i.cmd)
          CMD_PUSH: begin
            if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = stat_i.full ? STAT_PUSH_FULL : STAT_OK;
              cmd_o.push        = !stat_i.full;
            end
          end
          CMD_POP: begin
            if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = stat_i.empty ? STAT_POP_EMPTY : STAT_OK;
              cmd_o.pop         = !stat_i.empty;
            end
          end
          CMD_PEEK: begin
            if (!stat_i.empty) begin
              cmd_o.rd_en = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = STAT_PEEK_EMPTY;
            end
          end
          CMD_SWAP: begin
            if (!stat_i.short) begin
              cmd_o.rd_en = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = STAT_SWAP_SHORT;
            end
          end
          CMD_PRINT: begin
            cmd_o.ptr_init = !stat_i.empty;
          end
          default: ;
        endcase
      end
      ST_PEEK: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_data = 1'b1;
          cmd_o.emit_last = 1'b1;
        end
      end
      ST_SWAP_A: begin
        // hold the top value, fetch the one below it
        cmd_o.tmp_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RSEL_NEXT;
      end
      ST_SWAP_B: begin
        cmd_o.swap_wr_top = 1'b1;
      end
      ST_SWAP_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.swap_wr_next = 1'b1;
          cmd_o.emit         = 1'b1;
          cmd_o.emit_last    = 1'b1;
        end
      end
      ST_PR_READ: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RSEL_PTR;
        cmd_o.ptr_step = 1'b1;
      end
      ST_PR_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_data = 1'b1;
          cmd_o.emit_last = stat_i.print_last;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/sqe_dp.sv
module sqe_dp import sqe_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic [CmdW-1:0]          in_cmd_i,
  input  logic signed [ValueW-1:0] in_value_i,
  input  sqe_cmd_t                 cmd_i,
  output sqe_stat_t                stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] out_data_o,
  output logic                     out_has_data_o,
  output logic [StatusW-1:0]       out_status_o,
  output logic                     out_last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] MaxIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [ValueW-1:0] mem [DEPTH];

  logic                     mode_q;
  logic [CmdW-1:0]          cmd_q;
  logic [ValueW-1:0]        val_q;
  logic [AW-1:0]            top_q, top_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            ptr_q;
  logic [CW-1:0]            idx_q;
  logic [ValueW-1:0]        rdata_q;
  logic [ValueW-1:0]        tmp_q;
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_data_q;
  logic                     out_has_q;
  logic [StatusW-1:0]       out_status_q;
  logic                     out_last_q;

  logic [AW-1:0]     top_inc, top_dec, tail_addr, ptr_inc;
  logic [SW-1:0]     tail_sum;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [ValueW-1:0] wdata;
  logic [AW-1:0]     raddr;

  assign top_inc  = (top_q == MaxIdx) ? '0 : top_q + 1'b1;
  assign top_dec  = (top_q == '0) ? MaxIdx : top_q - 1'b1;
  assign ptr_inc  = (ptr_q == MaxIdx) ? '0 : ptr_q + 1'b1;
  assign tail_sum = {1'b0, top_q} + SW'(count_q);
  assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : tail_sum[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = top_q;
    wdata = rdata_q;
    if (cmd_i.push) begin
      we    = 1'b1;
      waddr = mode_q ? tail_addr : top_dec;
      wdata = val_q;
    end else if (cmd_i.swap_wr_top) begin
      we    = 1'b1;
      waddr = top_q;
      wdata = rdata_q;
    end else if (cmd_i.swap_wr_next) begin
      we    = 1'b1;
      waddr = top_inc;
      wdata = tmp_q;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RSEL_TOP:  raddr = top_q;
      RSEL_NEXT: raddr = top_inc;
      RSEL_PTR:  raddr = ptr_q;
      default:   raddr = top_q;
    endcase
  end

  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
      if (!mode_q) top_d = top_dec;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
      top_d   = top_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      top_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      top_q   <= top_d;
      count_q <= count_d;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_cmd_i;
      val_q <= in_value_i;
    end
    if (cmd_i.tmp_load) tmp_q <= rdata_q;
    if (cmd_i.ptr_init) begin
      ptr_q <= top_q;
      idx_q <= '0;
    end else begin
      if (cmd_i.ptr_step) ptr_q <= ptr_inc;
      if (cmd_i.emit && cmd_i.emit_data) idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_data_q   <= cmd_i.emit_data ? rdata_q : '0;
      out_has_q    <= cmd_i.emit_data;
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == FullCnt);
  assign stat_o.short      = (count_q < CW'(2));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.print_last = ((idx_q + 1'b1) == count_q);

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_has_data_o = out_has_q;
  assign out_status_o   = out_status_q;
  assign out_last_o     = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count above depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop on empty store");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not advance the count");
`endif

endmodule

>>> verif/tb_top.sv
module tb_top;
  import sqe_pkg::*;

  localparam int unsigned Depth        = DepthDef;
  localparam int unsigned SettleCycles = 2 * Depth + 20;
  localparam int unsigned CycleLimit   = 500_000;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 68;
  localparam int unsigned HoldCycles   = 300;

  // Command codes the block must ignore
  localparam logic [CmdW-1:0] CMD_RSV_A = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSV_B = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSV_C = 3'd7;

  typedef struct packed {
    logic [ValueW-1:0]  data;
    logic               has;
    logic [StatusW-1:0] status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [ValueW-1:0]  value;
    logic               typed;
    logic [ValueW-1:0]  exp_data;
    logic               exp_has;
    logic [StatusW-1:0] exp_status;
  } dir_row_t;

  localparam int NumDir = 24;
  // Stack mode from reset; typed rows carry their single expected result
  localparam dir_row_t DirRows [NumDir] = '{
    '{CMD_PEEK,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_PEEK_EMPTY},
    '{CMD_POP,   32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b0, STAT_POP_EMPTY},
    '{CMD_SWAP,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_SWAP_SHORT},
    '{CMD_PRINT, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PUSH,  32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_SWAP,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_SWAP_SHORT},
    '{CMD_PEEK,  32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1, STAT_OK},
    '{CMD_PUSH,  32'h7fff_ffff, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PUSH,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PUSH,  32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PRINT, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_SWAP,  32'h5555_5555, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PEEK,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_RSV_A, 32'hffff_ffff, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_RSV_B, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_RSV_C, 32'haaaa_aaaa, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PRINT, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_POP,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_POP,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_PEEK,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_POP,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_POP,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_OK},
    '{CMD_POP,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, STAT_POP_EMPTY},
    '{CMD_PRINT, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, STAT_OK}
  };

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              s_valid   = 1'b0;
  logic              s_ready;
  logic [ValueW-1:0] s_data    = '0;
  logic [CmdW-1:0]   s_user    = CMD_PUSH;
  logic              m_valid;
  logic              m_ready   = 1'b0;
  logic [ValueW-1:0] m_data;
  logic [StatusW:0]  m_user;
  logic              m_last;

  // Predictor state
  logic [ValueW-1:0] stored_vals [Depth];
  int unsigned       top_ptr  = 0;
  int unsigned       fill_cnt = 0;
  logic              mode_q   = 1'b0;

  result_t     step_results [$];
  result_t     pending_results [$];
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 55;
  bit          stall_go      = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned errors        = 0;
  int unsigned requests_done = 0;
  int unsigned reserved_cnt  = 0;
  int unsigned results_seen  = 0;
  int unsigned full_hits     = 0;
  int unsigned empty_hits    = 0;

  stack_queue_engine #(.DEPTH(Depth)) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("[stack_queue_engine] ERROR");
      $finish;
    end
  end

  function automatic result_t status_only(input logic [StatusW-1:0] st);
    return result_t'({{ValueW{1'b0}}, 1'b0, st, 1'b1});
  endfunction

  function automatic int unsigned slot_of(input int unsigned offset);
    return (top_ptr + offset) % Depth;
  endfunction

  task automatic predict_results(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
    int unsigned i;
    step_results.delete();
    case (cmd)
      CMD_PUSH: begin
        if (fill_cnt >= Depth) begin
          full_hits++;
          step_results.push_back(status_only(STAT_PUSH_FULL));
        end else begin
          if (mode_q) begin
            stored_vals[slot_of(fill_cnt)] = value;
          end else begin
            top_ptr = slot_of(Depth - 1);
            stored_vals[top_ptr] = value;
          end
          fill_cnt++;
          step_results.push_back(status_only(STAT_OK));
        end
      end
      CMD_PRINT: begin
        for (i = 0; i < fill_cnt; i++)
          step_results.push_back(result_t'({stored_vals[slot_of(i)], 1'b1, STAT_OK,
                                            (i + 1 == fill_cnt)}));
      end
      CMD_PEEK: begin
        if (fill_cnt == 0) begin
          empty_hits++;
          step_results.push_back(status_only(STAT_PEEK_EMPTY));
        end else begin
          step_results.push_back(result_t'({stored_vals[top_ptr], 1'b1, STAT_OK, 1'b1}));
        end
      end
      CMD_POP: begin
        if (fill_cnt == 0) begin
          empty_hits++;
          step_results.push_back(status_only(STAT_POP_EMPTY));
        end else begin
          top_ptr = slot_of(1);
          fill_cnt--;
          step_results.push_back(status_only(STAT_OK));
        end
      end
      CMD_SWAP: begin
        if (fill_cnt < 2) begin
          step_results.push_back(status_only(STAT_SWAP_SHORT));
        end else begin
          {stored_vals[slot_of(0)], stored_vals[slot_of(1)]} =
            {stored_vals[slot_of(1)], stored_vals[slot_of(0)]};
          step_results.push_back(status_only(STAT_OK));
        end
      end
      default: ;  // reserved codes: ignore
    endcase
  endtask

  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value,
                              input logic typed, input result_t fixed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_user  <= cmd;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_results(cmd, value);
    if (typed) begin
      pending_results.push_back(fixed);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    if (cmd > CMD_SWAP) reserved_cnt++;
    else requests_done++;
  endtask

  // Drop valid and hold until every expected result is out; optionally settle after
  task automatic drain_results(input bit settle);
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    if (settle) repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mode_q = mode;
  endtask

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    errors++;
    $display("%s at cycle %0d: got %h/%b/%0d/%b want %h/%b/%0d/%b", what, cycle_cnt,
             got.data, got.has, got.status, got.last,
             want.data, want.has, want.status, want.last);
  endtask

  always @(negedge clk) begin
    if (stall_go) begin
      stall_go   = 1'b0;
      stall_left = HoldCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && m_valid && m_ready) begin
      got.data   = m_data;
      got.has    = m_user[0];
      got.status = m_user[StatusW:1];
      got.last   = m_last;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.has !== want.has ||
            got.status !== want.status || got.last !== want.last)
          report_mismatch("result mismatch", got, want);
      end
    end
  end

  initial begin : stimulus
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
    int unsigned       r;
    int unsigned       n;
    bit                filling;
    bit                at_full;
    bit                at_empty;
    bit                paused;
    filling = 1'b1;
    paused  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < NumDir; row++)
      send_request(DirRows[row].cmd, DirRows[row].value, DirRows[row].typed,
                   result_t'({DirRows[row].exp_data, DirRows[row].exp_has,
                              DirRows[row].exp_status, 1'b1}));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results(1'b1);
      // entries stay in place across a mode change
      write_mode((ph % 2) == 0);
      case (ph / 2)
        0:       begin send_idle_pct = 33; recv_idle_pct = 55; end
        1:       begin send_idle_pct = 55; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 1) stall_go = 1'b1;
      n = 0;
      while (n < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 4) cmd = CmdW'($urandom_range(CMD_RSV_C, CMD_RSV_A));
        else if (r < (filling ? 74 : 16)) cmd = CMD_PUSH;
        else if (r < (filling ? 82 : 76)) cmd = CMD_POP;
        else begin
          r = $urandom_range(9);
          cmd = (r < 4) ? CMD_PEEK : (r < 8) ? CMD_SWAP : CMD_PRINT;
        end
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7fff_ffff;
            2:       value = '0;
            default: value = '1;
          endcase
        end else begin
          value = $urandom;
        end
        at_full  = (cmd == CMD_PUSH) && (fill_cnt >= Depth);
        at_empty = (cmd == CMD_POP) && (fill_cnt == 0);
        send_request(cmd, value, 1'b0, '0);
        if (cmd <= CMD_SWAP) n++;
        // sweep between full and empty
        if (filling && at_full) filling = 1'b0;
        else if (!filling && at_empty) filling = 1'b1;
        if (ph == 3 && n == PhaseItems / 2 && !paused) begin
          paused = 1'b1;
          drain_results(1'b0);
        end
      end
    end

    drain_results(1'b1);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("ran %0d requests plus %0d reserved codes, %0d results, stack and queue modes",
             requests_done, reserved_cnt, results_seen);
    $display("hit push-full %0d times and empty peek/pop %0d times, %0d mismatches",
             full_hits, empty_hits, errors);
    if (errors == 0) begin
      $display("[stack_queue_engine] OK");
    end else begin
      $display("[stack_queue_engine] ERROR");
    end
    $finish;
  end

endmodule
